>>> sv/efq_pkg.sv
// Package for the quaternion to Euler angle pipeline: widths, fixed-point
// constants, the arctangent table and the per-stage step functions.
// Depends on nothing.
package efq_pkg;

  localparam int CORDIC_STAGES   = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ISQRT_STEPS     = 31;
  localparam int CW              = 38;
  localparam int ZW              = 34;
  localparam int RND_SH          = 30 - ANGLE_FRAC_BITS;

  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [ZW-1:0] zw_t;

  localparam zw_t ONE_Q30     = zw_t'(64'd1073741824);
  localparam zw_t PI_Q30      = zw_t'(64'd3373259426);
  localparam zw_t HALF_PI_Q30 = zw_t'(64'd1686629713);

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [31:0] s;
    logic               lock;
    cw_t                roll_y;
    cw_t                roll_x;
    cw_t                yaw_y;
    cw_t                yaw_x;
  } pay_t;

  typedef struct packed {
    cw_t  x;
    cw_t  y;
    zw_t  z;
    logic zero;
  } lane_t;

  function automatic lane_t cordic_pre(cw_t y, cw_t x);
    lane_t l;
    l.zero = (x == '0) && (y == '0);
    l.x = x;
    l.y = y;
    l.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        l.x = y;
        l.y = -x;
        l.z = HALF_PI_Q30;
      end else begin
        l.x = -y;
        l.y = x;
        l.z = -HALF_PI_Q30;
      end
    end
    return l;
  endfunction

  function automatic lane_t cordic_step(lane_t l, int i);
    lane_t n;
    zw_t   a;
    a = zw_t'(ATAN_TAB[i % 32]);
    n.zero = l.zero;
    if (l.y >= 0) begin
      n.x = l.x + (l.y >>> (i % 32));
      n.y = l.y - (l.x >>> (i % 32));
      n.z = l.z + a;
    end else begin
      n.x = l.x - (l.y >>> (i % 32));
      n.y = l.y + (l.x >>> (i % 32));
      n.z = l.z - a;
    end
    return n;
  endfunction

  function automatic logic signed [ZW:0] to_angle(zw_t z, zw_t lim);
    logic signed [ZW:0] t;
    zw_t c;
    c = z;
    if (c > lim) c = lim;
    if (c < -lim) c = -lim;
    t = (ZW+1)'(c) + ((ZW+1)'(1) <<< (RND_SH - 1));
    return t >>> RND_SH;
  endfunction

endpackage

>>> sv/euler_from_quaternion_unit.sv
// Top level: quaternion to roll, pitch and yaw, fully pipelined.
// Uses efq_pkg for widths, constants and stage functions.
//
// One item enters per cycle while the output item is not stalled. Each item
// passes the 31-step square-root pipeline that forms cos(pitch) from the
// sine, then a quadrant stage and 16 CORDIC vectoring stages run in parallel
// for pitch, roll and yaw. The whole pipeline advances together; it holds
// while the output item is stalled. lock_tolerance (offset 0x0) sets how close
// |sin(pitch)| must come to one for gimbal lock.
module euler_from_quaternion_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [14:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o,
  output logic               gimbal_lock_o
);

  localparam int NS = efq_pkg::ISQRT_STEPS;
  localparam int NC = efq_pkg::CORDIC_STAGES;

  logic [14:0] tol_q;
  logic        en;

  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {17'd0, tol_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= 15'd4;
    end else if (psel && penable && pwrite && (paddr == 3'd0)) begin
      tol_q <= pwdata[14:0];
    end
  end

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // input stage
  logic               v0_q;
  logic signed [15:0] qx_q, qy_q, qz_q, qw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qx_q <= quat_x_i;
      qy_q <= quat_y_i;
      qz_q <= quat_z_i;
      qw_q <= quat_w_i;
    end
  end

  // products
  logic               v1_q;
  logic signed [31:0] yw_q, xz_q, yz_q, xw_q, ww_q, zz_q, xy_q, zw_q, yy_q, xx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= v0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      yw_q <= qy_q * qw_q;
      xz_q <= qx_q * qz_q;
      yz_q <= qy_q * qz_q;
      xw_q <= qx_q * qw_q;
      ww_q <= qw_q * qw_q;
      zz_q <= qz_q * qz_q;
      xy_q <= qx_q * qy_q;
      zw_q <= qz_q * qw_q;
      yy_q <= qy_q * qy_q;
      xx_q <= qx_q * qx_q;
    end
  end

  // sine of pitch, lock decision, atan2 operands
  logic               v2_q;
  efq_pkg::pay_t      p2_d, p2_q;
  logic signed [33:0] sd;
  logic signed [31:0] s_sat;
  logic [31:0]        mag, thr;
  efq_pkg::cw_t       one_c;

  always_comb begin
    one_c = efq_pkg::cw_t'(efq_pkg::ONE_Q30);
    sd    = (34'(yw_q) - 34'(xz_q)) <<< 1;
    if (sd > 34'sd1073741824) s_sat = 32'sd1073741824;
    else if (sd < -34'sd1073741824) s_sat = -32'sd1073741824;
    else s_sat = sd[31:0];
    mag  = s_sat[31] ? 32'(-s_sat) : 32'(s_sat);
    thr  = 32'd1073741824 - {2'b00, tol_q, 15'd0};
    p2_d.s      = s_sat;
    p2_d.lock   = mag >= thr;
    p2_d.roll_y = (efq_pkg::cw_t'(yz_q) + efq_pkg::cw_t'(xw_q)) <<< 1;
    p2_d.roll_x = ((efq_pkg::cw_t'(ww_q) + efq_pkg::cw_t'(zz_q)) <<< 1) - one_c;
    if (p2_d.lock) begin
      p2_d.yaw_y = -((efq_pkg::cw_t'(xy_q) - efq_pkg::cw_t'(zw_q)) <<< 1);
      p2_d.yaw_x = ((efq_pkg::cw_t'(ww_q) + efq_pkg::cw_t'(yy_q)) <<< 1) - one_c;
    end else begin
      p2_d.yaw_y = (efq_pkg::cw_t'(xy_q) + efq_pkg::cw_t'(zw_q)) <<< 1;
      p2_d.yaw_x = ((efq_pkg::cw_t'(ww_q) + efq_pkg::cw_t'(xx_q)) <<< 1) - one_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) p2_q <= p2_d;
  end

  // square of the sine
  logic               v3_q;
  efq_pkg::pay_t      p3_q;
  logic signed [63:0] ss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_q <= p2_q;
      ss_q <= p2_q.s * p2_q.s;
    end
  end

  // root pipeline: cos(pitch) = isqrt(2^60 - s*s)
  logic          sqv_q [NS+1];
  efq_pkg::pay_t sqp_q [NS+1];
  logic [61:0]   sqr_q [NS+1];
  logic [61:0]   sqrem_q [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sqv_q[0] <= 1'b0;
    else if (en) sqv_q[0] <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqp_q[0]   <= p3_q;
      sqr_q[0]   <= '0;
      sqrem_q[0] <= (62'd1 << 60) - 62'(ss_q);
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_sq
    logic [61:0] bit_c, tmp_c, r_d, rem_d;

    always_comb begin
      bit_c = 62'd1 << (60 - 2 * k);
      tmp_c = sqr_q[k] + bit_c;
      if (sqrem_q[k] >= tmp_c) begin
        rem_d = sqrem_q[k] - tmp_c;
        r_d   = (sqr_q[k] >> 1) + bit_c;
      end else begin
        rem_d = sqrem_q[k];
        r_d   = sqr_q[k] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sqv_q[k+1] <= 1'b0;
      else if (en) sqv_q[k+1] <= sqv_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sqp_q[k+1]   <= sqp_q[k];
        sqr_q[k+1]   <= r_d;
        sqrem_q[k+1] <= rem_d;
      end
    end
  end

  // CORDIC lanes: pitch, roll, yaw
  logic           cv_q [NC+1];
  logic           clk_lock_q [NC+1];
  efq_pkg::lane_t cp_q [NC+1];
  efq_pkg::lane_t cr_q [NC+1];
  efq_pkg::lane_t cy_q [NC+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cv_q[0] <= 1'b0;
    else if (en) cv_q[0] <= sqv_q[NS];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      clk_lock_q[0] <= sqp_q[NS].lock;
      cp_q[0] <= efq_pkg::cordic_pre(efq_pkg::cw_t'(sqp_q[NS].s),
                                     efq_pkg::cw_t'({1'b0, sqr_q[NS][30:0]}));
      cr_q[0] <= efq_pkg::cordic_pre(sqp_q[NS].roll_y, sqp_q[NS].roll_x);
      cy_q[0] <= efq_pkg::cordic_pre(sqp_q[NS].yaw_y, sqp_q[NS].yaw_x);
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) cv_q[i+1] <= 1'b0;
      else if (en) cv_q[i+1] <= cv_q[i];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        clk_lock_q[i+1] <= clk_lock_q[i];
        cp_q[i+1] <= efq_pkg::cordic_step(cp_q[i], i);
        cr_q[i+1] <= efq_pkg::cordic_step(cr_q[i], i);
        cy_q[i+1] <= efq_pkg::cordic_step(cy_q[i], i);
      end
    end
  end

  // output register
  logic                        ov_q, olock_q;
  logic signed [15:0]          oroll_q, oyaw_q;
  logic signed [14:0]          opitch_q;
  logic signed [efq_pkg::ZW:0] ar_c, ap_c, ay_c;
  efq_pkg::zw_t                zr_c, zp_c, zy_c;

  always_comb begin
    zr_c = (cr_q[NC].zero || clk_lock_q[NC]) ? '0 : cr_q[NC].z;
    zp_c = cp_q[NC].zero ? '0 : cp_q[NC].z;
    zy_c = cy_q[NC].zero ? '0 : cy_q[NC].z;
    ar_c = efq_pkg::to_angle(zr_c, efq_pkg::PI_Q30);
    ap_c = efq_pkg::to_angle(zp_c, efq_pkg::HALF_PI_Q30);
    ay_c = efq_pkg::to_angle(zy_c, efq_pkg::PI_Q30);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (en) ov_q <= cv_q[NC];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oroll_q  <= ar_c[15:0];
      opitch_q <= ap_c[14:0];
      oyaw_q   <= ay_c[15:0];
      olock_q  <= clk_lock_q[NC];
    end
  end

  assign out_valid_o   = ov_q;
  assign roll_angle_o  = oroll_q;
  assign pitch_angle_o = opitch_q;
  assign yaw_angle_o   = oyaw_q;
  assign gimbal_lock_o = olock_q;

endmodule

>>> sim/euler_from_quaternion_unit_test.sv
// Self-checking testbench for euler_from_quaternion_unit: drives quaternion
// items and APB writes, and checks roll, pitch, yaw and the gimbal lock flag.
// Depends on efq_pkg and the unit RTL.
module euler_from_quaternion_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_Q30    = 64'sd1073741824;
  localparam longint PI_Q30     = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam int     LIMIT      = 400000;
  localparam int     DRAIN      = 70;
  localparam int     PHASE_ITEMS = 300;
  localparam logic [2:0] LOCK_TOL_ADDR = 3'd0;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               lock;
  } angles_t;

  class angle_board;
    angles_t     angle_q[$];
    logic [14:0] tol;
    int          errors;

    function new();
      tol = 15'd4;
      errors = 0;
    endfunction

    function longint isqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return longint'(res);
    endfunction

    function longint atan2_q30(longint y, longint x);
      longint z, t, nx, ny;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;
          y = -t;
          z = HALF_PI_Q30;
        end else begin
          x = -y;
          y = t;
          z = -HALF_PI_Q30;
        end
      end
      for (int i = 0; i < efq_pkg::CORDIC_STAGES; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> (i % 32));
          ny = y - (x >>> (i % 32));
          z = z + longint'(efq_pkg::ATAN_TAB[i % 32]);
        end else begin
          nx = x - (y >>> (i % 32));
          ny = y + (x >>> (i % 32));
          z = z - longint'(efq_pkg::ATAN_TAB[i % 32]);
        end
        x = nx;
        y = ny;
      end
      return z;
    endfunction

    function longint round_angle(longint z, longint lim);
      if (z > lim) z = lim;
      if (z < -lim) z = -lim;
      return (z + (64'sd1 <<< (29 - efq_pkg::ANGLE_FRAC_BITS))) >>>
             (30 - efq_pkg::ANGLE_FRAC_BITS);
    endfunction

    function void note_item(logic signed [15:0] qx, logic signed [15:0] qy,
                            logic signed [15:0] qz, logic signed [15:0] qw);
      longint x, y, z, w, s, c, mag, roll, yaw, pitch;
      angles_t a;
      x = longint'(qx); y = longint'(qy); z = longint'(qz); w = longint'(qw);
      roll = 0;
      s = 2 * (y * w - x * z);
      if (s > ONE_Q30) s = ONE_Q30;
      if (s < -ONE_Q30) s = -ONE_Q30;
      c = isqrt(longint'(ONE_Q30 * ONE_Q30 - s * s));
      pitch = atan2_q30(s, c);
      mag = (s < 0) ? -s : s;
      a.lock = mag >= ONE_Q30 - (longint'(tol) <<< 15);
      if (a.lock) begin
        yaw = atan2_q30(-2 * (x * y - z * w), 2 * (w * w + y * y) - ONE_Q30);
      end else begin
        roll = atan2_q30(2 * (y * z + x * w), 2 * (w * w + z * z) - ONE_Q30);
        yaw = atan2_q30(2 * (x * y + z * w), 2 * (w * w + x * x) - ONE_Q30);
      end
      a.roll = 16'(round_angle(roll, PI_Q30));
      a.pitch = 15'(round_angle(pitch, HALF_PI_Q30));
      a.yaw = 16'(round_angle(yaw, PI_Q30));
      angle_q.push_back(a);
    endfunction

    function void report(string what, int got, int want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      errors++;
    endfunction

    function void check_angles(angles_t got);
      angles_t want;
      if (angle_q.size() == 0) begin
        report("unexpected item", 1, 0);
        return;
      end
      want = angle_q.pop_front();
      if (got.roll !== want.roll) report("roll", int'(got.roll), int'(want.roll));
      if (got.pitch !== want.pitch) report("pitch", int'(got.pitch), int'(want.pitch));
      if (got.yaw !== want.yaw) report("yaw", int'(got.yaw), int'(want.yaw));
      if (got.lock !== want.lock) report("gimbal_lock", int'(got.lock), int'(want.lock));
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] quat_x_i = '0, quat_y_i = '0, quat_z_i = '0, quat_w_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] roll_angle_o;
  logic signed [14:0] pitch_angle_o;
  logic signed [15:0] yaw_angle_o;
  logic               gimbal_lock_o;

  angle_board board = new();
  int  burst_left = 0;
  int  cycle_count = 0;

  euler_from_quaternion_unit dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("euler_from_quaternion_unit_test: errors");
      $finish;
    end
  end

  // receiver: stall pattern re-chosen at random from four modes, one long hold-off
  initial begin
    int rcv_cycles, mode;
    angles_t got;
    rcv_cycles = 0;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.roll = roll_angle_o;
        got.pitch = pitch_angle_o;
        got.yaw = yaw_angle_o;
        got.lock = gimbal_lock_o;
        board.check_angles(got);
      end
      rcv_cycles++;
      if (rcv_cycles % 64 == 0) mode = $urandom_range(0, 3);
      if (rcv_cycles >= 2500 && rcv_cycles < 2800)
        out_stall_i <= 1'b1;
      else if (mode == 0)
        out_stall_i <= 1'b0;
      else if (mode == 1)
        out_stall_i <= ($urandom_range(0, 3) == 0);
      else if (mode == 2)
        out_stall_i <= ($urandom_range(0, 3) != 0);
      else
        out_stall_i <= 1'($urandom_range(0, 1));
    end
  end

  task automatic send_item(logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z, logic signed [15:0] w);
    int g;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      g = $urandom_range(0, 8);
      if (g > 0) begin
        in_valid_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    quat_x_i <= x;
    quat_y_i <= y;
    quat_z_i <= z;
    quat_w_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(x, y, z, w);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.angle_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_tolerance(logic [14:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= LOCK_TOL_ADDR;
    pwdata <= {17'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.tol = v;
  endtask

  task automatic send_random();
    real c[4];
    real n;
    int kind, sg;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      send_item(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      return;
    end
    n = 0.0;
    while (n < 1.0) begin
      for (int k = 0; k < 4; k++) c[k] = real'(int'($urandom_range(0, 65535)) - 32768);
      if (kind < 5) begin
        sg = $urandom_range(0, 1) ? 1 : -1;
        for (int k = 0; k < 4; k++) c[k] = c[k] / 128.0;
        c[1] = c[1] + 23170.0;
        c[3] = c[3] + sg * 23170.0;
      end
      n = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
    end
    for (int k = 0; k < 4; k++) c[k] = c[k] * 32767.0 / n;
    send_item(16'($rtoi(c[0])), 16'($rtoi(c[1])), 16'($rtoi(c[2])), 16'($rtoi(c[3])));
  endtask

  initial begin
    logic signed [15:0] dq[16][4];
    logic [14:0] tols[5];
    dq = '{'{0, 0, 0, 0}, '{0, 0, 0, 32767}, '{0, 0, 0, -32768},
           '{-32768, -32768, -32768, -32768}, '{32767, 32767, 32767, 32767},
           '{0, 32767, 0, 32767}, '{0, 32767, 0, -32767}, '{0, 23170, 0, 23170},
           '{0, -23170, 0, 23170}, '{23170, 0, -23170, 0}, '{32767, 0, 0, 0},
           '{0, 0, 32767, 0}, '{0, 32767, 0, 0}, '{16384, 16384, 16384, 16384},
           '{0, 23169, 0, 23171}, '{21845, -21846, 21845, -21846}};
    tols = '{15'd0, 15'd32767, 15'd100, 15'd1, 15'd4};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dq[i]) send_item(dq[i][0], dq[i][1], dq[i][2], dq[i][3]);
    for (int i = 0; i < PHASE_ITEMS; i++) send_random();
    drain();
    foreach (tols[t]) begin
      write_tolerance(t == 2 ? 15'($urandom) : tols[t]);
      foreach (dq[i]) send_item(dq[i][0], dq[i][1], dq[i][2], dq[i][3]);
      for (int i = 0; i < PHASE_ITEMS; i++) send_random();
      drain();
    end
    if (board.errors == 0) begin
      $display("euler_from_quaternion_unit_test: clean");
    end else begin
      $display("euler_from_quaternion_unit_test: errors");
    end
    $finish;
  end
endmodule
